@@ hw/rtl/pfpp_pkg.sv @@
// ----------------------------------------------------------------------------
// pfpp_pkg
// Shared types and codes for the paged frame store plotter.
// ----------------------------------------------------------------------------
package pfpp_pkg;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    MODE_SET  = 2'd0,
    MODE_CLR  = 2'd1,
    MODE_WIPE = 2'd2,
    MODE_READ = 2'd3
  } mode_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic wipe_req;
    logic clr_last;
    logic out_busy;
  } sts_t;

endpackage

@@ hw/rtl/pfpp_ram.sv @@
// ----------------------------------------------------------------------------
// pfpp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pfpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/pfpp_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfpp_ctrl
// Sequencer: reset clearing pass, request accept, store wipe, result hand-off.
// ----------------------------------------------------------------------------
module pfpp_ctrl
  import pfpp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [3:0] {
    S_INIT   = 4'b0001,
    S_IDLE   = 4'b0010,
    S_MODIFY = 4'b0100,
    S_WIPE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.clr_step = 1'b0;
    cmd.finish   = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.wipe_req ? S_WIPE : S_MODIFY;
        end
      end
      S_WIPE: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_MODIFY;
        end
      end
      S_MODIFY: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/pfpp_datapath.sv @@
// ----------------------------------------------------------------------------
// pfpp_datapath
// Placement, clipping, address generation, frame store RMW and result register.
// ----------------------------------------------------------------------------
module pfpp_datapath
  import pfpp_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 128,
  parameter int PAGE_COUNT     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [1:0]            in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int DEPTH  = PAGE_COUNT * SCREEN_COLUMNS;
  localparam int ROWS   = PAGE_COUNT * 8;
  localparam int AW     = $clog2(DEPTH);
  localparam int CALC_W = AW + 4;

  mode_t       in_mode;
  logic [6:0]  px;
  logic [4:0]  py;
  logic [7:0]  ox;
  logic [5:0]  oy;
  logic [9:0]  col_s;
  logic [7:0]  row_s;
  logic        pos_ok;
  logic [CALC_W-1:0] addr_calc;
  logic [AW-1:0]     addr;

  mode_t       mode_r;
  logic        ok_r;
  logic [AW-1:0] addr_r;
  logic [6:0]  col_r;
  logic [1:0]  page_r;
  logic [2:0]  bit_r;
  logic        last_r;

  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic          out_clip_r;
  logic          out_last_r;

  logic [7:0]  rd_data;
  logic [7:0]  mask;
  logic [7:0]  new_byte;
  logic        pix_wr;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic [7:0]  res_byte;
  logic [1:0]  res_page;
  logic [6:0]  res_col;
  logic        res_clip;

  assign in_mode = mode_t'(in_tuser);
  assign px      = in_tdata[6:0];
  assign py      = in_tdata[11:7];
  assign ox      = in_tdata[19:12];
  assign oy      = in_tdata[25:20];

  always_comb begin
    if (in_mode == MODE_READ) begin
      col_s = {3'b000, px};
      row_s = {3'b000, py};
    end else begin
      col_s = {3'b000, px} + {{2{ox[7]}}, ox};
      row_s = {3'b000, py} + {{2{oy[5]}}, oy};
    end
  end

  assign pos_ok = !col_s[9] && (col_s < 10'(SCREEN_COLUMNS)) &&
                  !row_s[7] && (row_s < 8'(ROWS));

  assign addr_calc = CALC_W'(row_s[6:3]) * CALC_W'(SCREEN_COLUMNS) + CALC_W'(col_s[8:0]);
  assign addr      = addr_calc[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      ok_r   <= pos_ok;
      addr_r <= addr;
      col_r  <= col_s[6:0];
      page_r <= row_s[4:3];
      bit_r  <= row_s[2:0];
      last_r <= in_tlast;
    end
  end

  // clearing pass counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clr_step) begin
      cnt_nxt = sts.clr_last ? '0 : cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign mask     = 8'b0000_0001 << bit_r;
  assign new_byte = (mode_r == MODE_SET) ? (rd_data | mask) : (rd_data & ~mask);
  assign pix_wr   = cmd.finish && ok_r && ((mode_r == MODE_SET) || (mode_r == MODE_CLR));

  assign ram_we    = cmd.clr_step || pix_wr;
  assign ram_waddr = cmd.clr_step ? cnt_r : addr_r;
  assign ram_wdata = cmd.clr_step ? 8'h00 : new_byte;

  pfpp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.accept),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_comb begin
    res_byte = 8'h00;
    res_page = 2'd0;
    res_col  = 7'd0;
    res_clip = 1'b0;
    case (mode_r)
      MODE_SET, MODE_CLR: begin
        res_clip = !ok_r;
        if (ok_r) begin
          res_byte = new_byte;
          res_page = page_r;
          res_col  = col_r;
        end
      end
      MODE_READ: begin
        res_clip = !ok_r;
        if (ok_r) begin
          res_byte = rd_data;
          res_page = page_r;
          res_col  = col_r;
        end
      end
      default: begin
        res_clip = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= {7'd0, res_col, res_page, res_byte};
      out_clip_r <= res_clip;
      out_last_r <= last_r;
    end
  end

  assign sts.wipe_req = (in_mode == MODE_WIPE);
  assign sts.clr_last = (cnt_r == AW'(DEPTH - 1));
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;
  assign out_tlast  = out_last_r;

endmodule

@@ hw/rtl/paged_framebuffer_pixel_plotter_core.sv @@
// ----------------------------------------------------------------------------
// paged_framebuffer_pixel_plotter_core
// Paged monochrome frame store with clipped pixel set/clear, wipe and readback.
// ----------------------------------------------------------------------------
// Result: loaded into the output register from S_MODIFY once the output is not stalled.
// Requests: one at a time; store read on accept, write-back as the result is registered.
// Wipe request: zeroes the store in S_WIPE, one store entry per cycle.
// Reset: synchronous, active low; then a clearing pass with in_tready low zeroes
// the store.
module paged_framebuffer_pixel_plotter_core
  import pfpp_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 128,
  parameter int PAGE_COUNT     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // point_x [6:0], point_y [11:7], offset_x [19:12], offset_y [25:20], zero [31:26]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode [1:0]
  input  logic [1:0]            in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // byte_value [7:0], page_index [9:8], column_index [16:10], zero [23:17]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // clipped [0]
  output logic                  out_tuser,
  output logic                  out_tlast
);

  cmd_t cmd;
  sts_t sts;

  pfpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pfpp_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .PAGE_COUNT     (PAGE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hw/rtl/pfpp_checker.sv @@
// ----------------------------------------------------------------------------
// pfpp_checker
// Port-level checks for the plotter core, bound to the top level.
// ----------------------------------------------------------------------------
module pfpp_checker
  import pfpp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [1:0]            in_tuser,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one still in flight");

  // clipped results carry no byte, page or column
  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("clipped result with non-zero payload");

  // reset starts the clearing pass with nothing pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or result straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind paged_framebuffer_pixel_plotter_core pfpp_checker u_pfpp_checker (.*);

@@ tb/sv/tb_paged_framebuffer_pixel_plotter_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_paged_framebuffer_pixel_plotter_core
// Self-checking bench for the paged frame store plotter. A shadow copy of the
// frame store is updated on every accepted request. Each result is compared,
// field by field, with the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_paged_framebuffer_pixel_plotter_core;
  import pfpp_pkg::*;

  localparam int COLUMNS = 128;
  localparam int PAGES   = 4;
  localparam int ROWS    = PAGES * 8;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [1:0] page_index;
    logic [6:0] column_index;
    logic       clipped;
    logic       sprite_done;
  } plot_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = MODE_SET;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  logic [7:0]   shadow_store [0:PAGES*COLUMNS-1];
  plot_result_t expected_q [$];
  int           mismatches    = 0;
  int           sent_count    = 0;
  int           stall_left    = 0;
  bit           steady_source = 1'b0;
  bit           steady_sink   = 1'b0;

  paged_framebuffer_pixel_plotter_core #(
    .SCREEN_COLUMNS(COLUMNS),
    .PAGE_COUNT    (PAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("** paged_framebuffer_pixel_plotter_core: FAILED **");
    $finish;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  // shadow store update and expected result for one request
  function automatic plot_result_t apply_point(mode_t mode, logic [6:0] px, logic [4:0] py,
                                               logic signed [7:0] ox, logic signed [5:0] oy,
                                               logic last);
    plot_result_t r;
    int x, y, page, slot;
    r = '0;
    r.sprite_done = last;
    case (mode)
      MODE_WIPE: begin
        foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      end
      MODE_READ: begin
        page = int'(py) / 8;
        if (int'(px) >= COLUMNS || page >= PAGES) begin
          r.clipped = 1'b1;
        end else begin
          r.byte_value   = shadow_store[page*COLUMNS + int'(px)];
          r.page_index   = page[1:0];
          r.column_index = px;
        end
      end
      default: begin
        x = int'(px) + int'(ox);
        y = int'(py) + int'(oy);
        if (x < 0 || x >= COLUMNS || y < 0 || y >= ROWS) begin
          r.clipped = 1'b1;
        end else begin
          page = y / 8;
          slot = page*COLUMNS + x;
          shadow_store[slot][y % 8] = (mode == MODE_SET);
          r.byte_value   = shadow_store[slot];
          r.page_index   = page[1:0];
          r.column_index = x[6:0];
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s, got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // called just after a rising edge; leaves in_tvalid high when no gap follows
  task automatic send_point(input mode_t mode, input logic [6:0] px, input logic [4:0] py,
                            input logic signed [7:0] ox, input logic signed [5:0] oy,
                            input logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'b0, oy, ox, py, px};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(apply_point(mode, px, py, ox, oy, last));
    sent_count++;
    gap = steady_source ? 0 : idle_length();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!steady_sink && $urandom_range(0, 5) == 0) begin
      stall_left <= idle_length();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    plot_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.byte_value   = out_tdata[7:0];
      got.page_index   = out_tdata[9:8];
      got.column_index = out_tdata[16:10];
      got.clipped      = out_tuser;
      got.sprite_done  = out_tlast;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.byte_value !== want.byte_value)
          report_mismatch("byte_value", got.byte_value, want.byte_value);
        if (got.page_index !== want.page_index)
          report_mismatch("page_index", got.page_index, want.page_index);
        if (got.column_index !== want.column_index)
          report_mismatch("column_index", got.column_index, want.column_index);
        if (got.clipped !== want.clipped)
          report_mismatch("clipped", got.clipped, want.clipped);
        if (got.sprite_done !== want.sprite_done)
          report_mismatch("sprite_done", got.sprite_done, want.sprite_done);
      end
    end
  end

  task automatic test_plot_corners();
    send_point(MODE_SET,  7'd0,   5'd0,  8'sd0,    6'sd0,   1'b0);
    send_point(MODE_SET,  7'd127, 5'd31, 8'sd0,    6'sd0,   1'b0);
    send_point(MODE_SET,  7'd0,   5'd0,  8'sd127,  6'sd31,  1'b0);
    send_point(MODE_SET,  7'd5,   5'd3,  -8'sd5,   -6'sd3,  1'b0);
    send_point(MODE_SET,  7'd127, 5'd31, -8'sd127, -6'sd31, 1'b1);
    send_point(MODE_SET,  7'd10,  5'd8,  8'sd0,    6'sd0,   1'b0);
    send_point(MODE_CLR,  7'd0,   5'd0,  8'sd0,    6'sd0,   1'b0);
    send_point(MODE_CLR,  7'd0,   5'd7,  8'sd0,    6'sd0,   1'b1);
    send_point(MODE_READ, 7'd127, 5'd31, 8'sd0,    6'sd0,   1'b0);
    send_point(MODE_READ, 7'd10,  5'd15, -8'sd128, -6'sd32, 1'b1);
    send_point(MODE_READ, 7'd0,   5'd0,  8'sd127,  6'sd31,  1'b0);
  endtask

  task automatic test_offscreen_clipping();
    send_point(MODE_SET, 7'd127, 5'd31, -8'sd128, -6'sd32, 1'b0);
    send_point(MODE_SET, 7'd127, 5'd0,  8'sd1,    6'sd0,   1'b0);
    send_point(MODE_SET, 7'd0,   5'd0,  8'sd0,    -6'sd1,  1'b0);
    send_point(MODE_SET, 7'd0,   5'd31, 8'sd0,    6'sd1,   1'b1);
    send_point(MODE_CLR, 7'd0,   5'd4,  -8'sd1,   6'sd0,   1'b1);
    send_point(MODE_CLR, 7'd127, 5'd31, 8'sd127,  6'sd31,  1'b0);
  endtask

  task automatic test_store_wipe();
    send_point(MODE_WIPE, 7'd0,   5'd0,  8'sd0,    6'sd0,   1'b1);
    send_point(MODE_READ, 7'd127, 5'd31, 8'sd0,    6'sd0,   1'b0);
    send_point(MODE_READ, 7'd10,  5'd8,  8'sd0,    6'sd0,   1'b0);
    send_point(MODE_SET,  7'd64,  5'd20, 8'sd0,    6'sd0,   1'b0);
    send_point(MODE_WIPE, 7'd127, 5'd31, -8'sd1,   -6'sd1,  1'b0);
    send_point(MODE_READ, 7'd64,  5'd16, 8'sd0,    6'sd0,   1'b1);
  endtask

  task automatic test_sprite_drawing(input int items);
    int start, n, reads, sprites;
    logic signed [7:0] ox;
    logic signed [5:0] oy;
    bit wide;
    mode_t mode;
    start   = sent_count;
    sprites = 0;
    while (sent_count - start < items) begin
      wide = ($urandom_range(0, 4) == 0);
      ox   = wide ? 8'($urandom) : 8'($urandom_range(0, 116));
      oy   = wide ? 6'($urandom) : 6'($urandom_range(0, 24));
      n    = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        mode = ($urandom_range(0, 6) == 0) ? MODE_CLR : MODE_SET;
        send_point(mode, wide ? 7'($urandom) : 7'($urandom_range(0, 11)),
                   wide ? 5'($urandom) : 5'($urandom_range(0, 7)), ox, oy, i == n - 1);
      end
      reads = $urandom_range(0, 3);
      for (int i = 0; i < reads; i++)
        send_point(MODE_READ, 7'(int'(ox) + $urandom_range(0, 11)), 5'($urandom),
                   8'($urandom), 6'($urandom), 1'($urandom));
      sprites++;
      if (sprites == 30) wait_for_drain();
      if ($urandom_range(0, 39) == 0)
        send_point(MODE_WIPE, 7'($urandom), 5'($urandom), 8'($urandom), 6'($urandom),
                   1'($urandom));
    end
  endtask

  task automatic test_back_to_back(input int items);
    steady_source = 1'b1;
    steady_sink   = 1'b1;
    for (int i = 0; i < items; i++)
      send_point($urandom_range(0, 1) ? MODE_SET : MODE_READ, 7'($urandom), 5'($urandom),
                 8'($urandom_range(0, 15)), 6'($urandom_range(0, 3)), 1'($urandom));
    steady_source = 1'b0;
    steady_sink   = 1'b0;
  endtask

  task automatic test_random_noise(input int items);
    mode_t mode;
    for (int i = 0; i < items; i++) begin
      mode = mode_t'($urandom_range(0, 3));
      if (mode == MODE_WIPE && $urandom_range(0, 7) != 0) mode = MODE_READ;
      send_point(mode, 7'($urandom), 5'($urandom), 8'($urandom), 6'($urandom),
                 1'($urandom));
    end
  endtask

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plot_corners();
    test_offscreen_clipping();
    test_store_wipe();
    test_sprite_drawing(1250);
    test_back_to_back(150);
    test_random_noise(430);
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (expected_q.size() != 0) report_mismatch("results missing", expected_q.size(), 0);
    if (mismatches == 0) begin
      $display("** paged_framebuffer_pixel_plotter_core: PASSED **");
    end else begin
      $display("** paged_framebuffer_pixel_plotter_core: FAILED **");
    end
    $finish;
  end

endmodule
